### rtl/ed_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ed_pkg
// Shared types and constants of the Euclidean divider pipeline.
// ----------------------------------------------------------------------------
package ed_pkg;

    // side-band flags that travel down the pipeline with each operand pair
    typedef struct packed {
        logic neg_a;     // dividend was negative
        logic neg_b;     // divisor was negative
        logic div_zero;  // divisor was zero
    } t_flags;

    // bit positions in the result tuser
    localparam int unsigned USER_DIV_ZERO = 0;
    localparam int unsigned USER_OVF      = 1;
    localparam int unsigned USER_W        = 2;

endpackage
`default_nettype wire

### rtl/ed_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ed_front
// Input stage: takes operand magnitudes, records signs and a zero divisor.
// ----------------------------------------------------------------------------
module ed_front #(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [WIDTH-1:0]  i_dividend,
    input  wire logic [WIDTH-1:0]  i_divisor,
    output logic                   o_valid,
    output logic [WIDTH-1:0]       o_rem,
    output logic [WIDTH-1:0]       o_quo,
    output logic [WIDTH-1:0]       o_dvs,
    output ed_pkg::t_flags         o_flags
);

    logic           n_neg_a;
    logic           n_neg_b;
    logic [WIDTH-1:0] n_mag_a;
    logic [WIDTH-1:0] n_mag_b;
    logic           r_valid;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_dvs;
    ed_pkg::t_flags r_flags;

    always_comb begin
        n_neg_a = i_dividend[WIDTH-1];
        n_neg_b = i_divisor[WIDTH-1];
        // the most negative value keeps its bit pattern, read as unsigned 2^(W-1)
        n_mag_a = n_neg_a ? (~i_dividend + 1'b1) : i_dividend;
        n_mag_b = n_neg_b ? (~i_divisor + 1'b1) : i_divisor;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo            <= n_mag_a;
            r_dvs            <= n_mag_b;
            r_flags.neg_a    <= n_neg_a;
            r_flags.neg_b    <= n_neg_b;
            r_flags.div_zero <= (i_divisor == '0);
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = '0;
    assign o_quo   = r_quo;
    assign o_dvs   = r_dvs;
    assign o_flags = r_flags;

endmodule
`default_nettype wire

### rtl/ed_div_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ed_div_stage
// One restoring division step: shifts in one dividend bit, settles one
// quotient bit.
// ----------------------------------------------------------------------------
module ed_div_stage #(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [WIDTH-1:0]  i_rem,
    input  wire logic [WIDTH-1:0]  i_quo,
    input  wire logic [WIDTH-1:0]  i_dvs,
    input  wire ed_pkg::t_flags    i_flags,
    output logic                   o_valid,
    output logic [WIDTH-1:0]       o_rem,
    output logic [WIDTH-1:0]       o_quo,
    output logic [WIDTH-1:0]       o_dvs,
    output ed_pkg::t_flags         o_flags
);

    logic [WIDTH-1:0] n_trial;
    logic [WIDTH:0]   n_diff;
    logic [WIDTH-1:0] n_rem;
    logic [WIDTH-1:0] n_quo;
    logic             r_valid;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_dvs;
    ed_pkg::t_flags   r_flags;

    always_comb begin
        // partial remainder stays below the divisor, so the shift fits in WIDTH bits
        n_trial = {i_rem[WIDTH-2:0], i_quo[WIDTH-1]};
        n_diff  = {1'b0, n_trial} - {1'b0, i_dvs};
        n_rem   = n_diff[WIDTH] ? n_trial : n_diff[WIDTH-1:0];
        n_quo   = {i_quo[WIDTH-2:0], ~n_diff[WIDTH]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem   <= n_rem;
            r_quo   <= n_quo;
            r_dvs   <= i_dvs;
            r_flags <= i_flags;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_dvs   = r_dvs;
    assign o_flags = r_flags;

endmodule
`default_nettype wire

### rtl/ed_fixup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ed_fixup
// Final stage: turns the unsigned quotient and remainder into the Euclidean
// result, applies signs, flags zero divisor and overflow.
// ----------------------------------------------------------------------------
module ed_fixup #(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [WIDTH-1:0]  i_rem,
    input  wire logic [WIDTH-1:0]  i_quo,
    input  wire logic [WIDTH-1:0]  i_dvs,
    input  wire ed_pkg::t_flags    i_flags,
    output logic                   o_valid,
    output logic [WIDTH-1:0]       o_quotient,
    output logic [WIDTH-2:0]       o_remainder,
    output logic                   o_div_zero,
    output logic                   o_ovf
);

    localparam logic [WIDTH-1:0] MaxPos = {1'b0, {(WIDTH-1){1'b1}}};

    logic             n_adj;
    logic             n_q_neg;
    logic             n_ovf;
    logic [WIDTH-1:0] n_rem_adj;
    logic [WIDTH-1:0] n_quo;
    logic [WIDTH-1:0] n_quotient;
    logic [WIDTH-2:0] n_remainder;
    logic             r_valid;
    logic [WIDTH-1:0] r_quotient;
    logic [WIDTH-2:0] r_remainder;
    logic             r_div_zero;
    logic             r_ovf;

    always_comb begin
        // negative dividend with a leftover: remainder flips, magnitude grows by one
        n_adj     = i_flags.neg_a && (i_rem != '0);
        n_q_neg   = i_flags.neg_a ^ i_flags.neg_b;
        n_rem_adj = n_adj ? (i_dvs - i_rem) : i_rem;
        // -(q + 1) is ~q, so the adjusted negative case needs no adder
        case ({n_adj, n_q_neg})
            2'b00:   n_quo = i_quo;
            2'b01:   n_quo = ~i_quo + 1'b1;
            2'b10:   n_quo = i_quo + 1'b1;
            2'b11:   n_quo = ~i_quo;
            default: n_quo = i_quo;
        endcase
        // only the most negative dividend over minus one gives a positive 2^(W-1) quotient
        n_ovf = !i_flags.div_zero && !n_q_neg && i_quo[WIDTH-1];
        if (i_flags.div_zero) begin
            n_quotient  = '0;
            n_remainder = '0;
        end else if (n_ovf) begin
            n_quotient  = MaxPos;
            n_remainder = '0;
        end else begin
            n_quotient  = n_quo;
            n_remainder = n_rem_adj[WIDTH-2:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quotient  <= n_quotient;
            r_remainder <= n_remainder;
            r_div_zero  <= i_flags.div_zero;
            r_ovf       <= n_ovf;
        end
    end

    assign o_valid     = r_valid;
    assign o_quotient  = r_quotient;
    assign o_remainder = r_remainder;
    assign o_div_zero  = r_div_zero;
    assign o_ovf       = r_ovf;

endmodule
`default_nettype wire

### rtl/ed_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ed_out_buf
// Output register with a skid stage, so the pipeline advance is registered
// and never depends on the downstream ready in the same cycle.
// ----------------------------------------------------------------------------
module ed_out_buf #(
    parameter int unsigned DATA_W = 66
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_ready,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_data,
    input  wire logic              i_ready
);

    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;
    logic              r_skid_valid;
    logic [DATA_W-1:0] r_skid_data;
    logic              n_load;

    assign o_ready = !r_skid_valid;
    assign n_load  = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (n_load) begin
            // skid drains first; the pipeline is held while it is full
            r_out_valid  <= r_skid_valid || i_valid;
            r_skid_valid <= 1'b0;
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_out_data <= r_skid_valid ? r_skid_data : i_data;
        end else if (i_valid && !r_skid_valid) begin
            r_skid_data <= i_data;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule
`default_nettype wire

### rtl/euclidean_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// euclidean_divider
// Pipelined signed Euclidean division: remainder in [0, |divisor|), quotient
// with dividend = quotient * divisor + remainder.
// ----------------------------------------------------------------------------
//  channel   direction  tdata (low bits first)           tuser
//  s_axis    in         dividend, divisor                -
//  m_axis    out        quotient, remainder              divide_by_zero, quotient_overflow
//
//  one beat per cycle in and out while m_axis is not stalled; from accept to tvalid
//  a beat passes the input stage, one restoring stage per quotient bit, fix-up stage, output reg
//  reset clears every stage valid and the output buffer
//  a stall on m_axis holds the whole pipe while the skid stage is full;
//  s_axis_tready is a register output
// ----------------------------------------------------------------------------
module euclidean_divider #(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [((2*WIDTH + 7) / 8) * 8 - 1:0]     s_axis_tdata,   // dividend, divisor
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [((2*WIDTH - 1 + 7) / 8) * 8 - 1:0]      m_axis_tdata,   // quotient, remainder
    output logic [ed_pkg::USER_W-1:0] m_axis_tuser    // divide_by_zero, quotient_overflow
);

    localparam int unsigned IN_W  = ((2*WIDTH + 7) / 8) * 8;
    localparam int unsigned OUT_W = ((2*WIDTH - 1 + 7) / 8) * 8;
    localparam int unsigned RES_W = 2*WIDTH + 1;

    logic                 w_en;
    logic [WIDTH:0]       w_valid;
    logic [WIDTH-1:0]     w_rem   [0:WIDTH];
    logic [WIDTH-1:0]     w_quo   [0:WIDTH];
    logic [WIDTH-1:0]     w_dvs   [0:WIDTH];
    ed_pkg::t_flags       w_flags [0:WIDTH];

    logic                 w_fix_valid;
    logic [WIDTH-1:0]     w_quotient;
    logic [WIDTH-2:0]     w_remainder;
    logic                 w_div_zero;
    logic                 w_ovf;
    logic [RES_W-1:0]     w_res;
    logic [RES_W-1:0]     w_out;

    ed_front #(.WIDTH(WIDTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (s_axis_tvalid),
        .i_dividend (s_axis_tdata[WIDTH-1:0]),
        .i_divisor  (s_axis_tdata[2*WIDTH-1:WIDTH]),
        .o_valid    (w_valid[0]),
        .o_rem      (w_rem[0]),
        .o_quo      (w_quo[0]),
        .o_dvs      (w_dvs[0]),
        .o_flags    (w_flags[0])
    );

    for (genvar g = 0; g < WIDTH; g++) begin : g_stage
        ed_div_stage #(.WIDTH(WIDTH)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_valid[g]),
            .i_rem   (w_rem[g]),
            .i_quo   (w_quo[g]),
            .i_dvs   (w_dvs[g]),
            .i_flags (w_flags[g]),
            .o_valid (w_valid[g+1]),
            .o_rem   (w_rem[g+1]),
            .o_quo   (w_quo[g+1]),
            .o_dvs   (w_dvs[g+1]),
            .o_flags (w_flags[g+1])
        );
    end

    ed_fixup #(.WIDTH(WIDTH)) u_fixup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (w_valid[WIDTH]),
        .i_rem       (w_rem[WIDTH]),
        .i_quo       (w_quo[WIDTH]),
        .i_dvs       (w_dvs[WIDTH]),
        .i_flags     (w_flags[WIDTH]),
        .o_valid     (w_fix_valid),
        .o_quotient  (w_quotient),
        .o_remainder (w_remainder),
        .o_div_zero  (w_div_zero),
        .o_ovf       (w_ovf)
    );

    assign w_res = {w_ovf, w_div_zero, w_remainder, w_quotient};

    ed_out_buf #(.DATA_W(RES_W)) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fix_valid),
        .i_data  (w_res),
        .o_ready (w_en),
        .o_valid (m_axis_tvalid),
        .o_data  (w_out),
        .i_ready (m_axis_tready)
    );

    assign s_axis_tready = w_en;
    assign m_axis_tdata  = OUT_W'(w_out[2*WIDTH-2:0]);
    assign m_axis_tuser[ed_pkg::USER_DIV_ZERO] = w_out[2*WIDTH-1];
    assign m_axis_tuser[ed_pkg::USER_OVF]      = w_out[2*WIDTH];

endmodule
`default_nettype wire

### rtl/ed_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ed_checker
// Port-level checks of the Euclidean divider, bound to the top level.
// ----------------------------------------------------------------------------
module ed_checker #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned OUT_W = 64
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 s_axis_tready,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [OUT_W-1:0]     m_axis_tdata,
    input wire logic [ed_pkg::USER_W-1:0] m_axis_tuser
);

    localparam logic [WIDTH-1:0] MaxPos = {1'b0, {(WIDTH-1){1'b1}}};

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result beat changed while stalled");

    // zero divisor gives zero quotient and remainder and no overflow
    a_div_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[ed_pkg::USER_DIV_ZERO] |->
            m_axis_tdata[2*WIDTH-2:0] == '0 && !m_axis_tuser[ed_pkg::USER_OVF])
        else $error("divide by zero result not cleared");

    // overflow saturates the quotient and clears the remainder
    a_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[ed_pkg::USER_OVF] |->
            m_axis_tdata[WIDTH-1:0] == MaxPos && m_axis_tdata[2*WIDTH-2:WIDTH] == '0)
        else $error("overflow result not saturated");

    // input side only backs off after a result was refused
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input ready dropped without an output stall");

    // while the input side is held a result must be waiting
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input held with no result pending");

endmodule

bind euclidean_divider ed_checker #(
    .WIDTH (WIDTH),
    .OUT_W (OUT_W)
) u_ed_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire
